@@ sv/fha_pkg.sv @@
// Shared types, command codes and palette function for the fire heat automaton.
package fha_pkg;

  // Command codes carried in the input beat
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_IGNITE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIT_LEVEL  = 1'b1;

  localparam logic [7:0] DECAY_STEP_RST = 8'd20;
  localparam logic [7:0] LIT_LEVEL_RST  = 8'd255;

  // Palette thresholds on the 8-bit heat scale
  localparam logic [7:0] HEAT_DARK_MAX = 8'd12;
  localparam logic [7:0] HEAT_RED_MIN  = 8'd64;
  localparam logic [7:0] HEAT_ORG_MIN  = 8'd128;
  localparam logic [7:0] HEAT_WHT_MIN  = 8'd192;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
  } fha_in_t;

  typedef struct packed {
    logic [7:0] heat;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } fha_res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cnt_clr;
    logic cnt_inc;
    logic clr_wr;
    logic tick_rd;
    logic cap_read;
    logic set_pend;
    logic clr_pend;
    logic res_emit;
    logic res_from_mem;
  } fha_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cnt_last;
  } fha_sts_t;

  function automatic fha_res_t fha_palette(input logic [7:0] h);
    fha_res_t r;
    r.heat = h;
    if (h <= HEAT_DARK_MAX) begin
      r.red = 8'd0;   r.green = 8'd0;   r.blue = 8'd0;   r.alpha = 8'd0;
    end else if (h >= HEAT_WHT_MIN) begin
      r.red = 8'd255; r.green = 8'd255; r.blue = 8'd220; r.alpha = 8'd255;
    end else if (h >= HEAT_ORG_MIN) begin
      r.red = 8'd255; r.green = 8'd200; r.blue = 8'd80;  r.alpha = 8'd255;
    end else if (h >= HEAT_RED_MIN) begin
      r.red = 8'd240; r.green = 8'd120; r.blue = 8'd30;  r.alpha = 8'd255;
    end else begin
      r.red = 8'd140; r.green = 8'd30;  r.blue = 8'd10;  r.alpha = 8'd255;
    end
    return r;
  endfunction

endpackage

@@ sv/fha_ctrl.sv @@
// Sequencing state machine for the fire heat automaton.
module fha_ctrl
  import fha_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] command_i,
  input  fha_sts_t   sts_i,
  output fha_cmd_t   cmd_o,
  output logic       busy_o
);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_CLR   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;

  logic [2:0] state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          case (command_i)
            CMD_TICK: begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = S_TICK;
            end
            CMD_IGNITE: begin
              cmd_o.set_pend = 1'b1;
              cmd_o.res_emit = 1'b1;
            end
            CMD_READ: begin
              cmd_o.cap_read = 1'b1;
              state_d        = S_READ;
            end
            CMD_CLEAR: begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = S_CLR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_TICK: begin
        cmd_o.tick_rd = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        // last write of the sweep lands here
        cmd_o.res_emit = 1'b1;
        cmd_o.clr_pend = 1'b1;
        state_d        = S_IDLE;
      end
      S_CLR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.res_emit = 1'b1;
          cmd_o.clr_pend = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.res_emit     = 1'b1;
        cmd_o.res_from_mem = 1'b1;
        state_d            = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // Read accept moves to the response cycle
  a_read_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_READ) |=> (state_q == S_READ))
    else $error("read did not enter response state");

  // Tick sweep ends in the drain cycle
  a_tick_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK && sts_i.cnt_last) |=> (state_q == S_DRAIN))
    else $error("tick sweep did not drain");

  // Clear writes never overlap tick reads
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.clr_wr && cmd_o.tick_rd))
    else $error("clear and tick active together");

endmodule

@@ sv/fha_datapath.sv @@
// Heat grid memory, sweep counter, config registers and result register.
module fha_datapath
  import fha_pkg::*;
#(
  parameter int unsigned GRID_W = 16,
  parameter int unsigned GRID_H = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fha_cmd_t             cmd_i,
  output fha_sts_t             sts_o,
  input  logic [5:0]           cell_x_i,
  input  logic [5:0]           cell_y_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  output fha_res_t             res_o,
  output logic                 done_o
);

  localparam int unsigned CELLS = GRID_W * GRID_H;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned BOT   = CELLS - GRID_W;

  logic [7:0]    mem [CELLS];
  logic [7:0]    rdata_q;
  logic [AW-1:0] cnt_q;
  logic          wr_vld_q;
  logic [AW-1:0] wr_addr_q;
  logic          wr_bot_q;
  logic          pend_q;
  logic          inrange_q;
  logic [7:0]    decay_q, lit_q;
  fha_res_t      res_q;
  logic          done_q;

  logic [AW:0]   tick_sum;
  logic          cnt_bot;
  logic [12:0]   cell_lin;
  logic          in_range;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [7:0]    decayed;
  logic [7:0]    heat_src;

  // Sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign sts_o.cnt_last = (cnt_q == AW'(CELLS - 1));

  // Read addressing: source row below during a tick, else the requested cell
  assign tick_sum = {1'b0, cnt_q} + (AW + 1)'(GRID_W);
  assign cnt_bot  = (cnt_q >= AW'(BOT));
  assign cell_lin = 13'(cell_y_i) * 13'(GRID_W) + 13'(cell_x_i);
  assign in_range = ({1'b0, cell_x_i} < 7'(GRID_W)) && ({1'b0, cell_y_i} < 7'(GRID_H));
  assign rd_en    = cmd_i.tick_rd ? !cnt_bot : (cmd_i.cap_read && in_range);
  assign raddr    = cmd_i.tick_rd ? tick_sum[AW-1:0] : cell_lin[AW-1:0];

  // Write side: clear sweep writes directly, a tick write lands in the cycle after its read
  assign decayed = (rdata_q > decay_q) ? (rdata_q - decay_q) : 8'd0;
  assign we      = cmd_i.clr_wr || wr_vld_q;
  assign waddr   = cmd_i.clr_wr ? cnt_q : wr_addr_q;
  always_comb begin
    if (cmd_i.clr_wr) begin
      wdata = 8'd0;
    end else if (wr_bot_q) begin
      wdata = pend_q ? lit_q : 8'd0;
    end else begin
      wdata = decayed;
    end
  end

  // Grid memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // Tick write pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_vld_q <= 1'b0;
    end else begin
      wr_vld_q <= cmd_i.tick_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= cnt_q;
    wr_bot_q  <= cnt_bot;
    if (cmd_i.cap_read) begin
      inrange_q <= in_range;
    end
  end

  // Ignite flag and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      decay_q <= DECAY_STEP_RST;
      lit_q   <= LIT_LEVEL_RST;
    end else begin
      if (cmd_i.set_pend) begin
        pend_q <= 1'b1;
      end else if (cmd_i.clr_pend) begin
        pend_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DECAY_STEP: decay_q <= cfg_data_i;
          REG_LIT_LEVEL:  lit_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Result register
  assign heat_src = (cmd_i.res_from_mem && inrange_q) ? rdata_q : 8'd0;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_emit) begin
      res_q <= fha_palette(heat_src);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.res_emit;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

@@ sv/fire_heat_automaton.sv @@
// Top level of the fire heat automaton: controller plus datapath.
//
// Usage: drive in_i and raise start_i; the beat is taken at a clock edge
// where start_i is high and busy_o is low. Every command gives exactly one
// result beat on res_o, marked by done_o for one cycle; the receiver must
// take it then, it cannot stall the block.
// Commands: tick shifts the grid up one row with decay and refills the
// bottom row; ignite arms the bottom-row fill for the next tick; read returns
// a cell's heat and palette color; clear zeroes the grid and the ignite flag.
// Ignite leaves busy_o low; read, clear and tick hold busy_o high until
// their result beat. The next command can be taken at the edge that takes
// the result beat. Tick and clear are paced by the single write port of
// the grid memory, one cell per cycle; tick adds a drain state for its
// last write, and the result beat comes in the cycle in which busy_o drops.
// Config: cfg_we_i writes decay_step (index 0) or lit_level (index 1) at
// once; write only while the block is idle.
// Reset: a clearing pass over every cell zeroes the grid with busy_o high;
// config writes are taken during it.
module fire_heat_automaton
  import fha_pkg::*;
#(
  parameter int unsigned GRID_W = 16,
  parameter int unsigned GRID_H = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  fha_in_t              in_i,
  output logic                 done_o,
  output fha_res_t             res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_data_i
);

  fha_cmd_t cmd;
  fha_sts_t sts;

  fha_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (in_i.command),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy_o)
  );

  fha_datapath #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cell_x_i   (in_i.cell_x),
    .cell_y_i   (in_i.cell_y),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res_o),
    .done_o     (done_o)
  );

endmodule
